>>> sv/uapq_pkg.sv
// Shared types and constants for the unsorted array priority queue.
`default_nettype none

package uapq_pkg;

  localparam int DEPTH  = 16;
  localparam int PRIO_W = 16;
  localparam int TAG_W  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int STAT_W = 2;
  localparam int CMD_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_OFFER = 2'd0,
    CMD_POLL  = 2'd1,
    CMD_PEEK  = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [PRIO_W-1:0] item_priority;
    logic [TAG_W-1:0]         item_tag;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [PRIO_W-1:0] out_priority;
    logic [TAG_W-1:0]         out_tag;
    logic [CNT_W-1:0]         occupancy;
  } rsp_t;

endpackage

`default_nettype wire

>>> sv/unsorted_array_priority_queue_unit.sv
// Top level of the unsorted array priority queue with its scan and shift sequencer.
`default_nettype none

// Entries are held in arrival order. An offer, an unused command, and a poll or
// peek on an empty queue give their result in the cycle after start while busy
// stays low, so such commands may follow each other on every cycle. A poll or
// peek on a queue of N entries runs one comparator over the entries, one per
// cycle; a peek then reports. A poll goes on to close the gap, moving one later
// entry down per cycle from just above the winner, and then makes a final check
// that ends the command. Each result is shown for exactly one cycle under done
// and must be taken then, as the receiver cannot stall it. The capacity register
// is written through the cfg channel, which is ready whenever the block is not
// busy.
module unsorted_array_priority_queue_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire uapq_pkg::req_t               req,
  output      logic                         done,
  output      uapq_pkg::rsp_t               rsp,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [uapq_pkg::CNT_W-1:0]   cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  state_t                             state;
  uapq_pkg::cmd_t                     op;
  logic [uapq_pkg::CNT_W-1:0]         count;
  logic [uapq_pkg::CNT_W-1:0]         limit;
  logic [uapq_pkg::CNT_W-1:0]         idx;
  logic [uapq_pkg::CNT_W-1:0]         best_idx;
  logic signed [uapq_pkg::PRIO_W-1:0] best_prio;
  logic [uapq_pkg::TAG_W-1:0]         best_tag;

  logic signed [uapq_pkg::PRIO_W-1:0] prio_mem [uapq_pkg::DEPTH];
  logic [uapq_pkg::TAG_W-1:0]         tag_mem  [uapq_pkg::DEPTH];

  logic                               accept;
  logic                               full;
  logic signed [uapq_pkg::PRIO_W-1:0] rd_prio;
  logic [uapq_pkg::TAG_W-1:0]         rd_tag;
  logic                               take;
  logic [uapq_pkg::CNT_W-1:0]         best_idx_next;
  logic signed [uapq_pkg::PRIO_W-1:0] best_prio_next;
  logic [uapq_pkg::TAG_W-1:0]         best_tag_next;
  logic                               scan_last;
  logic                               wr_en;
  logic [uapq_pkg::IDX_W-1:0]         wr_addr;
  logic signed [uapq_pkg::PRIO_W-1:0] wr_prio;
  logic [uapq_pkg::TAG_W-1:0]         wr_tag;
  logic [uapq_pkg::CNT_W-1:0]         idx_dec;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign accept    = start && !busy;
  assign full      = (count >= limit) ||
                     (count >= uapq_pkg::CNT_W'(uapq_pkg::DEPTH));

  // One read port, addressed by the sequencer index in both scan and shift.
  assign rd_prio = prio_mem[idx[uapq_pkg::IDX_W-1:0]];
  assign rd_tag  = tag_mem[idx[uapq_pkg::IDX_W-1:0]];

  // The first entry is taken unconditionally; later ones only if strictly
  // greater, so the earliest arrival wins a tie.
  assign take           = (idx == '0) || (rd_prio > best_prio);
  assign best_idx_next  = take ? idx     : best_idx;
  assign best_prio_next = take ? rd_prio : best_prio;
  assign best_tag_next  = take ? rd_tag  : best_tag;
  assign scan_last      = (idx == count - 1'b1);
  assign idx_dec        = idx - 1'b1;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[uapq_pkg::IDX_W-1:0];
    wr_prio = req.item_priority;
    wr_tag  = req.item_tag;
    if (accept && (req.cmd == uapq_pkg::CMD_OFFER) && !full) begin
      wr_en = 1'b1;
    end else if ((state == S_SHIFT) && (idx < count)) begin
      wr_en   = 1'b1;
      wr_addr = idx_dec[uapq_pkg::IDX_W-1:0];
      wr_prio = rd_prio;
      wr_tag  = rd_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prio_mem[wr_addr] <= wr_prio;
      tag_mem[wr_addr]  <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      op       <= uapq_pkg::CMD_OFFER;
      count    <= '0;
      limit    <= uapq_pkg::CNT_W'(uapq_pkg::DEPTH);
      idx      <= '0;
      best_idx <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        limit <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op               <= req.cmd;
            rsp.out_priority <= '0;
            rsp.out_tag      <= '0;
            rsp.occupancy    <= count;
            rsp.status       <= uapq_pkg::ST_OK;
            unique case (req.cmd)
              uapq_pkg::CMD_OFFER: begin
                done <= 1'b1;
                if (full) begin
                  rsp.status <= uapq_pkg::ST_FULL;
                end else begin
                  count         <= count + 1'b1;
                  rsp.occupancy <= count + 1'b1;
                end
              end
              uapq_pkg::CMD_POLL, uapq_pkg::CMD_PEEK: begin
                if (count == '0) begin
                  done       <= 1'b1;
                  rsp.status <= uapq_pkg::ST_EMPTY;
                end else begin
                  idx      <= '0;
                  best_idx <= '0;
                  state    <= S_SCAN;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          best_idx  <= best_idx_next;
          best_prio <= best_prio_next;
          best_tag  <= best_tag_next;
          idx       <= idx + 1'b1;
          if (scan_last) begin
            rsp.out_priority <= best_prio_next;
            rsp.out_tag      <= best_tag_next;
            if (op == uapq_pkg::CMD_PEEK) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              // Later entries move down one place, starting just above the winner.
              idx   <= best_idx_next + 1'b1;
              state <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (idx < count) begin
            idx <= idx + 1'b1;
          end else begin
            count         <= count - 1'b1;
            rsp.occupancy <= count - 1'b1;
            done          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking testbench for the unsorted array priority queue unit.
module tb_top;
  import uapq_pkg::*;

  localparam cmd_t CMD_UNUSED  = cmd_t'(2'd3);
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   PHASES      = 10;
  localparam int   PHASE_ITEMS = 125;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  req_t             req = '0;
  logic             done;
  rsp_t             rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  unsorted_array_priority_queue_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the queue contents and the capacity register.
  logic signed [PRIO_W-1:0] held_prio [DEPTH];
  logic [TAG_W-1:0]         held_tag  [DEPTH];
  int unsigned              held_count = 0;
  logic [CNT_W-1:0]         cap_setting = 5'd16;

  req_t pending_cmds  [$];
  rsp_t expected_rsps [$];
  rsp_t oldest_rsp;
  rsp_t expected_rsp;

  bit gaps_on = 1'b1;
  int mismatches = 0;
  int cycle_count = 0;
  int n_offer = 0, n_poll = 0, n_peek = 0, n_unused = 0;
  int n_full = 0, n_empty = 0, peak_fill = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Applies one command to the shadow queue and returns the result it should give.
  function automatic rsp_t apply_command(input req_t cmd_in);
    rsp_t        res;
    int unsigned room;
    int unsigned top;
    int unsigned k;
    res = '0;
    res.status = ST_OK;
    room = (cap_setting > DEPTH) ? DEPTH : cap_setting;
    case (cmd_in.cmd)
      CMD_OFFER: begin
        if (held_count >= room) begin
          res.status = ST_FULL;
        end else begin
          held_prio[held_count] = cmd_in.item_priority;
          held_tag[held_count]  = cmd_in.item_tag;
          held_count++;
        end
      end
      CMD_POLL, CMD_PEEK: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // Strictly greater, so the earliest arrival keeps a tie.
          top = 0;
          for (k = 1; k < held_count; k++) begin
            if (held_prio[k] > held_prio[top]) top = k;
          end
          res.out_priority = held_prio[top];
          res.out_tag      = held_tag[top];
          if (cmd_in.cmd == CMD_POLL) begin
            for (k = top; k + 1 < held_count; k++) begin
              held_prio[k] = held_prio[k + 1];
              held_tag[k]  = held_tag[k + 1];
            end
            held_count--;
          end
        end
      end
      default: ;
    endcase
    res.occupancy = held_count[CNT_W-1:0];
    return res;
  endfunction

  function automatic req_t make_cmd(input cmd_t c, input logic [PRIO_W-1:0] p,
                                    input logic [TAG_W-1:0] t);
    req_t r;
    r.cmd           = c;
    r.item_priority = p;
    r.item_tag      = t;
    return r;
  endfunction

  // Driver: a transaction is taken at an edge where start is high and busy is low.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        oldest_rsp = apply_command(pending_cmds[0]);
        case (pending_cmds[0].cmd)
          CMD_OFFER: n_offer++;
          CMD_POLL:  n_poll++;
          CMD_PEEK:  n_peek++;
          default:   n_unused++;
        endcase
        if (oldest_rsp.status == ST_FULL) n_full++;
        if (oldest_rsp.status == ST_EMPTY) n_empty++;
        if (int'(oldest_rsp.occupancy) > peak_fill) peak_fill = oldest_rsp.occupancy;
        expected_rsps.push_back(oldest_rsp);
        void'(pending_cmds.pop_front());
      end
      if (pending_cmds.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 15)) begin
        start <= 1'b1;
        req   <= pending_cmds[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results cannot be held off, so each strobe is checked as it comes.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result: status %0d priority %0d tag %0d occupancy %0d",
               rsp.status, rsp.out_priority, rsp.out_tag, rsp.occupancy);
        mismatches++;
      end else begin
        expected_rsp = expected_rsps.pop_front();
        if (rsp.status !== expected_rsp.status) begin
          $error("status: expected %0d, got %0d", expected_rsp.status, rsp.status);
          mismatches++;
        end
        if (rsp.out_priority !== expected_rsp.out_priority) begin
          $error("out_priority: expected %0d, got %0d",
                 expected_rsp.out_priority, rsp.out_priority);
          mismatches++;
        end
        if (rsp.out_tag !== expected_rsp.out_tag) begin
          $error("out_tag: expected 0x%04h, got 0x%04h", expected_rsp.out_tag, rsp.out_tag);
          mismatches++;
        end
        if (rsp.occupancy !== expected_rsp.occupancy) begin
          $error("occupancy: expected %0d, got %0d", expected_rsp.occupancy, rsp.occupancy);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d commands pending and %0d results outstanding.",
               pending_cmds.size(), expected_rsps.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || expected_rsps.size() != 0 || start || busy)
      @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_setting = value;
  endtask

  task automatic queue_random(input int count, input int offer_pct);
    int                  r;
    int                  sel;
    cmd_t                c;
    logic [PRIO_W-1:0]   p;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 2)              c = CMD_UNUSED;
      else if (r < offer_pct) c = CMD_OFFER;
      else if (r < offer_pct + (100 - offer_pct) * 2 / 3) c = CMD_POLL;
      else                    c = CMD_PEEK;
      // A narrow band of priorities makes ties frequent.
      sel = $urandom_range(0, 9);
      if (sel == 0)     p = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      else if (sel < 4) p = PRIO_W'($urandom_range(0, 6) - 3);
      else              p = PRIO_W'($urandom);
      pending_cmds.push_back(make_cmd(c, p, TAG_W'($urandom)));
    end
  endtask

  initial begin
    int caps [PHASES];
    int offer_share [PHASES];
    caps        = '{31, 2, 17, 0, 16, 1, 9, 31, 5, 16};
    offer_share = '{75, 55, 60, 45, 65, 50, 60, 70, 50, 40};
    caps[8] = $urandom_range(0, 31);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Empty queue and the unused command at the reset capacity.
    pending_cmds.push_back(make_cmd(CMD_POLL, 16'h0000, 16'h0000));
    pending_cmds.push_back(make_cmd(CMD_PEEK, 16'h7fff, 16'hffff));
    pending_cmds.push_back(make_cmd(CMD_UNUSED, 16'h8000, 16'hffff));

    write_capacity(5'd4);
    pending_cmds.push_back(make_cmd(CMD_OFFER, 16'h8000, 16'h0000));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 16'h7fff, 16'hffff));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 16'h7fff, 16'h0001));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 16'hffff, 16'h5a5a));
    pending_cmds.push_back(make_cmd(CMD_OFFER, 16'h0000, 16'ha5a5));
    pending_cmds.push_back(make_cmd(CMD_PEEK, 16'h0000, 16'h0000));
    pending_cmds.push_back(make_cmd(CMD_POLL, 16'h0000, 16'h0000));
    pending_cmds.push_back(make_cmd(CMD_PEEK, 16'h0000, 16'h0000));
    repeat (4) pending_cmds.push_back(make_cmd(CMD_POLL, 16'hffff, 16'hffff));

    write_capacity(5'd0);
    pending_cmds.push_back(make_cmd(CMD_OFFER, 16'h0005, 16'h0001));
    pending_cmds.push_back(make_cmd(CMD_PEEK, 16'h0000, 16'h0000));

    // The queue carries over between phases, so a low capacity can follow a full queue.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(caps[ph][CNT_W-1:0]);
      gaps_on = !(ph == 4 || ph == 5);
      queue_random(PHASE_ITEMS, offer_share[ph]);
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (expected_rsps.size() != 0) begin
      $error("%0d results never arrived", expected_rsps.size());
      mismatches++;
    end
    $display("Ran %0d offers (%0d refused as full), %0d polls, %0d peeks, %0d unused commands.",
             n_offer, n_full, n_poll, n_peek, n_unused);
    $display("Capacities from 0 to 31 were set; %0d empty reports; occupancy peaked at %0d.",
             n_empty, peak_fill);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
